// File: design/rvm_pkg.sv
// Shared constants, types and register codes for the windowed RMS voltage monitor.
package rvm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int SQ_BITS        = 2 * SAMPLE_BITS;
    localparam int ACC_BITS       = 40;
    localparam int SUM_BITS       = ((SQ_BITS > ACC_BITS) ? SQ_BITS : ACC_BITS) + 1;
    localparam int ROOT_BITS      = ACC_BITS / 2;
    localparam int COUNT_BITS     = 8;
    localparam int CODE_BITS      = 16;
    localparam int VOLT_BITS      = 16;
    localparam int VPC_BITS       = 24;
    localparam int FRAC_SHIFT     = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 24;
    localparam int S_TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS   = CODE_BITS + VOLT_BITS;
    localparam int M_TUSER_BITS   = 2;

    localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLTS_PER_CODE = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_VOLTAGE    = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_VOLTAGE    = 8'd3;

    localparam logic [COUNT_BITS-1:0] WINDOW_LENGTH_RST  = 8'd200;
    localparam logic [VPC_BITS-1:0]   VOLTS_PER_CODE_RST = 24'd10486;
    localparam logic [VOLT_BITS-1:0]  MIN_VOLTAGE_RST    = 16'd0;
    localparam logic [VOLT_BITS-1:0]  MAX_VOLTAGE_RST    = 16'hFFFF;

    typedef struct packed {
        logic [COUNT_BITS-1:0] window_length;
        logic [VPC_BITS-1:0]   volts_per_code;
        logic [VOLT_BITS-1:0]  min_voltage;
        logic [VOLT_BITS-1:0]  max_voltage;
    } cfg_t;

    typedef struct packed {
        logic [ACC_BITS-1:0]   square_sum;
        logic [COUNT_BITS-1:0] sample_count;
    } window_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] rms_code;
        logic [VOLT_BITS-1:0] rms_voltage;
        logic                 under_voltage;
        logic                 over_voltage;
    } result_t;

endpackage

// File: design/rvm_front.sv
// Front end: squares samples, accumulates the window and posts closed windows to the queue.
module rvm_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rvm_pkg::SAMPLE_BITS-1:0]     sample_code,
    input  logic [rvm_pkg::COUNT_BITS-1:0]      window_length,
    input  rvm_pkg::queue_status_t              q_status,
    output logic                                q_push,
    output rvm_pkg::window_t                    q_entry
);
    import rvm_pkg::*;

    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_BITS-1:0]     sq_next;
    logic [SQ_BITS-1:0]     sq_reg;
    logic                   sq_valid_reg;
    logic                   sq_valid_next;
    logic [ACC_BITS-1:0]    sum_reg;
    logic [ACC_BITS-1:0]    sum_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [SUM_BITS-1:0]    sum_wide;
    logic [ACC_BITS-1:0]    sum_sat;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [COUNT_BITS-1:0]  win;
    logic                   close;
    logic                   advance;

    always_comb begin
        mag       = sample_code[SAMPLE_BITS-1] ? (~sample_code + 1'b1) : sample_code;
        sq_next   = SQ_BITS'(mag) * SQ_BITS'(mag);
        sum_wide  = SUM_BITS'(sum_reg) + SUM_BITS'(sq_reg);
        sum_sat   = (sum_wide > SUM_BITS'(ACC_MAX)) ? ACC_MAX : sum_wide[ACC_BITS-1:0];
        count_inc = count_reg + 1'b1;
        // a zero length closes on every sample
        win       = (window_length == '0) ? COUNT_BITS'(1) : window_length;
        close     = sq_valid_reg && (count_inc >= win);
        advance   = sq_valid_reg && (!close || !q_status.full);
        s_tready  = !sq_valid_reg || advance;
        q_push    = close && !q_status.full;
        q_entry.square_sum   = sum_sat;
        q_entry.sample_count = count_inc;

        sq_valid_next = s_tready ? s_tvalid : sq_valid_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        if (advance) begin
            sum_next   = close ? '0 : sum_sat;
            count_next = close ? '0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
        end else begin
            sq_valid_reg <= sq_valid_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sq_reg <= sq_next;
        end
    end

endmodule

// File: design/rvm_queue.sv
// Two-entry queue of closed windows between the front and back ends.
module rvm_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  rvm_pkg::window_t       push_entry,
    input  logic                   pop,
    output rvm_pkg::window_t       head_entry,
    output rvm_pkg::queue_status_t status
);
    import rvm_pkg::*;

    window_t    mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    always_comb begin
        status.empty = (fill_reg == 2'd0);
        status.full  = (fill_reg == 2'd2);
        head_entry   = mem[rd_ptr_reg];
        fill_next    = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: design/rvm_back.sv
// Back end: serial divide, digit-by-digit root, scaling, flags and the result register.
module rvm_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rvm_pkg::cfg_t          cfg,
    input  rvm_pkg::queue_status_t q_status,
    input  rvm_pkg::window_t       q_head,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output rvm_pkg::result_t       result
);
    import rvm_pkg::*;

    localparam int STEP_BITS = $clog2(ACC_BITS);
    localparam int SREM_BITS = ROOT_BITS + 1;
    localparam int SSH_BITS  = ROOT_BITS + 3;
    localparam int PROD_BITS = ROOT_BITS + VPC_BITS;
    localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (FRAC_SHIFT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t                 state_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [ACC_BITS-1:0]    dq_reg;
    logic [COUNT_BITS-1:0]  divisor_reg;
    logic [COUNT_BITS-1:0]  drem_reg;
    logic [SREM_BITS-1:0]   srem_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic                   m_valid_reg;
    result_t                result_reg;

    logic [COUNT_BITS:0]    div_trial;
    logic [COUNT_BITS:0]    div_diff;
    logic                   div_ge;
    logic [SSH_BITS-1:0]    sq_shift;
    logic [SSH_BITS-1:0]    sq_trial;
    logic [SSH_BITS-1:0]    sq_diff;
    logic                   sq_ge;
    logic [PROD_BITS:0]     rounded;
    logic [VOLT_BITS-1:0]   volts;
    logic [CODE_BITS-1:0]   code;
    logic                   out_free;

    always_comb begin
        div_trial = {drem_reg, dq_reg[ACC_BITS-1]};
        div_diff  = div_trial - {1'b0, divisor_reg};
        div_ge    = div_trial >= {1'b0, divisor_reg};

        sq_shift  = {srem_reg, dq_reg[ACC_BITS-1 -: 2]};
        sq_trial  = SSH_BITS'({root_reg, 2'b01});
        sq_diff   = sq_shift - sq_trial;
        sq_ge     = sq_shift >= sq_trial;

        rounded   = (PROD_BITS + 1)'(prod_reg) + ROUND_HALF;
        volts     = (|rounded[PROD_BITS:VOLT_BITS+FRAC_SHIFT]) ? '1
                  : rounded[VOLT_BITS+FRAC_SHIFT-1:FRAC_SHIFT];
        code      = (|root_reg[ROOT_BITS-1:CODE_BITS]) ? '1 : root_reg[CODE_BITS-1:0];

        out_free  = !m_valid_reg || m_tready;
        q_pop     = (state_reg == ST_IDLE) && !q_status.empty;
        m_tvalid  = m_valid_reg;
        result    = result_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_status.empty) begin
                        dq_reg      <= q_head.square_sum;
                        divisor_reg <= q_head.sample_count;
                        drem_reg    <= '0;
                        step_reg    <= '0;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // shift one quotient bit in per cycle
                    drem_reg <= div_ge ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
                    dq_reg   <= {dq_reg[ACC_BITS-2:0], div_ge};
                    if (step_reg == STEP_BITS'(ACC_BITS - 1)) begin
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_SQRT;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SQRT: begin
                    // take two bits of the mean per root bit
                    srem_reg <= sq_ge ? sq_diff[SREM_BITS-1:0] : sq_shift[SREM_BITS-1:0];
                    root_reg <= {root_reg[ROOT_BITS-2:0], sq_ge};
                    dq_reg   <= {dq_reg[ACC_BITS-3:0], 2'b00};
                    if (step_reg == STEP_BITS'(ROOT_BITS - 1)) begin
                        state_reg <= ST_MUL;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= PROD_BITS'(root_reg) * PROD_BITS'(cfg.volts_per_code);
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        result_reg.rms_code      <= code;
                        result_reg.rms_voltage   <= volts;
                        result_reg.under_voltage <= volts < cfg.min_voltage;
                        result_reg.over_voltage  <= volts > cfg.max_voltage;
                        m_valid_reg              <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/windowed_rms_voltage_monitor.sv
// Windowed RMS voltage monitor: the front end takes one signed sample per cycle, squares it
// and adds it into a 40-bit saturating sum; the sample that completes a window of
// window_length samples (zero counts as one) posts the sum and sample count to a two-entry
// queue, stalling the input only while the queue is full. The back end works on one window
// at a time through a shared serial unit: it takes the window from the queue, runs a 40-bit
// restoring divide and a 20-bit square root, then one multiply and a rounding and compare
// step, after which the result sits in the output register until taken. Input therefore
// runs at one sample per cycle while the queue has room; windows that close faster than the
// back end finishes them stall the input at its pace once the queue fills. rms_voltage is
// the root times volts_per_code (Q8.16) rounded to a 16-bit integer and saturated. There is
// no start-up clearing pass; the configuration port is always ready.
module windowed_rms_voltage_monitor (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rvm_pkg::S_TDATA_BITS-1:0]     s_tdata,   // [15:0] sample_code
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rvm_pkg::M_TDATA_BITS-1:0]     m_tdata,   // [15:0] rms_code, [31:16] rms_voltage
    output logic [rvm_pkg::M_TUSER_BITS-1:0]     m_tuser,   // [0] under_voltage, [1] over_voltage
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rvm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rvm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import rvm_pkg::*;

    cfg_t          cfg_reg;
    queue_status_t q_status;
    window_t       push_entry;
    window_t       head_entry;
    logic          q_push;
    logic          q_pop;
    result_t       result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length  <= WINDOW_LENGTH_RST;
            cfg_reg.volts_per_code <= VOLTS_PER_CODE_RST;
            cfg_reg.min_voltage    <= MIN_VOLTAGE_RST;
            cfg_reg.max_voltage    <= MAX_VOLTAGE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH:  cfg_reg.window_length  <= cfg_data[COUNT_BITS-1:0];
                CFG_VOLTS_PER_CODE: cfg_reg.volts_per_code <= cfg_data[VPC_BITS-1:0];
                CFG_MIN_VOLTAGE:    cfg_reg.min_voltage    <= cfg_data[VOLT_BITS-1:0];
                CFG_MAX_VOLTAGE:    cfg_reg.max_voltage    <= cfg_data[VOLT_BITS-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    rvm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .sample_code   (s_tdata[SAMPLE_BITS-1:0]),
        .window_length (cfg_reg.window_length),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    rvm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    rvm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_head   (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = {result.rms_voltage, result.rms_code};
    assign m_tuser = {result.over_voltage, result.under_voltage};

endmodule

// File: design/rvm_checker.sv
// Port-level checks on the result channel of the monitor, bound to the top level.
module rvm_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [rvm_pkg::M_TDATA_BITS-1:0]     m_tdata,
    input logic [rvm_pkg::M_TUSER_BITS-1:0]     m_tuser
);
    import rvm_pkg::*;

    // a stalled request holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a zero root scales to zero volts whatever the gain
    a_zero_volts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[CODE_BITS-1:0] == '0) |-> (m_tdata[M_TDATA_BITS-1:CODE_BITS] == '0))
        else $error("nonzero voltage for zero code");

endmodule

bind windowed_rms_voltage_monitor rvm_checker u_rvm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
